[src/rcsp_pkg.sv]
// Shared types and constants for the RESP command stream parser.
`default_nettype none
package rcsp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned EventW   = 2;
  localparam int unsigned ArgIdxW  = 10;
  localparam int unsigned BytesW   = 24;

  localparam logic [ByteW-1:0] ChStar   = 8'h2A;  // '*'
  localparam logic [ByteW-1:0] ChDollar = 8'h24;  // '$'
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  localparam logic [EventW-1:0] EvData     = 2'd0;
  localparam logic [EventW-1:0] EvArgDone  = 2'd1;
  localparam logic [EventW-1:0] EvEmptyCmd = 2'd2;
  localparam logic [EventW-1:0] EvError    = 2'd3;

  // Received byte together with its character class.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_digit;
    logic             is_cr;
    logic             is_lf;
    logic             is_star;
    logic             is_dollar;
  } byte_class_t;

endpackage
`default_nettype wire

[src/rcsp_front.sv]
// Front end: classifies incoming bytes and queues them for the parser.
`default_nettype none
module rcsp_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  [7:0]               byte_in_i,
  output logic                     q_valid_o,
  output rcsp_pkg::byte_class_t    q_entry_o,
  input  wire                      q_pop_i
);
  import rcsp_pkg::*;

  byte_class_t entries_q [2];
  byte_class_t cls;
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  logic        pop;

  always_comb begin
    cls.data      = byte_in_i;
    cls.is_digit  = (byte_in_i >= ChZero) && (byte_in_i <= ChNine);
    cls.is_cr     = (byte_in_i == ChCr);
    cls.is_lf     = (byte_in_i == ChLf);
    cls.is_star   = (byte_in_i == ChStar);
    cls.is_dollar = (byte_in_i == ChDollar);
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_entry_o  = entries_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

[src/rcsp_back.sv]
// Back end: protocol state machine and registered event output.
`default_nettype none
module rcsp_back #(
  parameter int unsigned MAX_ARGS       = 1024,
  parameter int unsigned MAX_ARG_LENGTH = 1048576
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      q_valid_i,
  input  rcsp_pkg::byte_class_t    q_entry_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic [1:0]               event_res_o,
  output logic [7:0]               data_byte_o,
  output logic [9:0]               arg_index_o,
  output logic                     command_done_o,
  output logic [23:0]              bytes_consumed_o
);
  import rcsp_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_ARGS + 1);
  localparam int unsigned LW  = $clog2(MAX_ARG_LENGTH + 1);
  localparam int unsigned AW  = (CW > LW) ? CW : LW;  // accumulator
  localparam int unsigned NW  = AW + 4;               // accum * 10 + 9
  localparam logic [NW-1:0] CntLim = NW'(MAX_ARGS);
  localparam logic [NW-1:0] LenLim = NW'(MAX_ARG_LENGTH);

  localparam logic [3:0] PhStar    = 4'd0;
  localparam logic [3:0] PhCntDig  = 4'd1;
  localparam logic [3:0] PhCntLf   = 4'd2;
  localparam logic [3:0] PhLenMark = 4'd3;
  localparam logic [3:0] PhLenDig  = 4'd4;
  localparam logic [3:0] PhLenLf   = 4'd5;
  localparam logic [3:0] PhData    = 4'd6;
  localparam logic [3:0] PhDataCr  = 4'd7;
  localparam logic [3:0] PhDataLf  = 4'd8;
  localparam logic [3:0] PhError   = 4'd9;

  logic [3:0]        phase_q, phase_d;
  logic [CW-1:0]     args_exp_q, args_exp_d;
  logic [CW-1:0]     cur_arg_q, cur_arg_d;
  logic [AW-1:0]     accum_q, accum_d;
  logic              digit_seen_q, digit_seen_d;
  logic [LW-1:0]     remain_q, remain_d;
  logic [BytesW-1:0] bcount_q, bcount_d;

  logic              out_valid_q, out_valid_d;
  logic [EventW-1:0] ev_q, ev_d;
  logic [ByteW-1:0]  db_q, db_d;
  logic [ArgIdxW-1:0] idx_q, idx_d;
  logic              done_q, done_d;
  logic [BytesW-1:0] bc_out_q, bc_out_d;

  logic              pop;
  logic              emit;
  logic [BytesW-1:0] bc_inc;
  logic [NW-1:0]     prod;
  logic [NW-1:0]     lim;
  logic [CW:0]       next_arg;
  logic              last_arg;
  logic [LW-1:0]     remain_dec;

  assign pop     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;
  assign bc_inc  = (bcount_q != {BytesW{1'b1}}) ? bcount_q + 1'b1 : bcount_q;
  // accum * 10 + digit, with shifts
  assign prod    = NW'({accum_q, 3'b000}) + NW'({accum_q, 1'b0})
                 + NW'(q_entry_i.data[3:0]);
  assign lim     = (phase_q == PhCntDig) ? CntLim : LenLim;
  assign next_arg = {1'b0, cur_arg_q} + 1'b1;
  assign last_arg = (next_arg >= {1'b0, args_exp_q});
  assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;

  always_comb begin
    phase_d      = phase_q;
    args_exp_d   = args_exp_q;
    cur_arg_d    = cur_arg_q;
    accum_d      = accum_q;
    digit_seen_d = digit_seen_q;
    remain_d     = remain_q;
    bcount_d     = bcount_q;
    emit         = 1'b0;
    ev_d         = EvError;
    db_d         = '0;
    idx_d        = ArgIdxW'(cur_arg_q);
    done_d       = 1'b0;

    if (pop && (phase_q != PhError)) begin
      bcount_d = bc_inc;
      unique case (phase_q)
        PhStar: begin
          if (q_entry_i.is_star) begin
            cur_arg_d    = '0;
            accum_d      = '0;
            digit_seen_d = 1'b0;
            phase_d      = PhCntDig;
          end else begin
            emit    = 1'b1;
            phase_d = PhError;
          end
        end
        PhCntDig, PhLenDig: begin
          if (q_entry_i.is_digit) begin
            digit_seen_d = 1'b1;
            if (prod > lim) begin
              emit    = 1'b1;
              phase_d = PhError;
            end else begin
              accum_d = prod[AW-1:0];
            end
          end else if (q_entry_i.is_cr && digit_seen_q) begin
            phase_d = (phase_q == PhCntDig) ? PhCntLf : PhLenLf;
          end else begin
            emit    = 1'b1;
            phase_d = PhError;
          end
        end
        PhCntLf: begin
          if (!q_entry_i.is_lf) begin
            emit    = 1'b1;
            phase_d = PhError;
          end else begin
            args_exp_d = accum_q[CW-1:0];
            if (accum_q[CW-1:0] == '0) begin
              emit     = 1'b1;
              ev_d     = EvEmptyCmd;
              idx_d    = '0;
              done_d   = 1'b1;
              bcount_d = '0;
              phase_d  = PhStar;
            end else begin
              phase_d = PhLenMark;
            end
          end
        end
        PhLenMark: begin
          if (q_entry_i.is_dollar) begin
            accum_d      = '0;
            digit_seen_d = 1'b0;
            phase_d      = PhLenDig;
          end else begin
            emit    = 1'b1;
            phase_d = PhError;
          end
        end
        PhLenLf: begin
          if (!q_entry_i.is_lf) begin
            emit    = 1'b1;
            phase_d = PhError;
          end else begin
            remain_d = accum_q[LW-1:0];
            phase_d  = (accum_q[LW-1:0] == '0) ? PhDataCr : PhData;
          end
        end
        PhData: begin
          emit     = 1'b1;
          ev_d     = EvData;
          db_d     = q_entry_i.data;
          remain_d = remain_dec;
          if (remain_dec == '0) begin
            phase_d = PhDataCr;
          end
        end
        PhDataCr: begin
          if (q_entry_i.is_cr) begin
            phase_d = PhDataLf;
          end else begin
            emit    = 1'b1;
            phase_d = PhError;
          end
        end
        PhDataLf: begin
          if (!q_entry_i.is_lf) begin
            emit    = 1'b1;
            phase_d = PhError;
          end else begin
            emit   = 1'b1;
            ev_d   = EvArgDone;
            done_d = last_arg;
            if (last_arg) begin
              bcount_d  = '0;
              cur_arg_d = '0;
              phase_d   = PhStar;
            end else begin
              cur_arg_d = next_arg[CW-1:0];
              phase_d   = PhLenMark;
            end
          end
        end
        default: begin
          emit    = 1'b1;
          phase_d = PhError;
        end
      endcase
    end

    // event carries the count including this byte
    bc_out_d = bc_inc;

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStar;
      args_exp_q   <= '0;
      cur_arg_q    <= '0;
      accum_q      <= '0;
      digit_seen_q <= 1'b0;
      remain_q     <= '0;
      bcount_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      args_exp_q   <= args_exp_d;
      cur_arg_q    <= cur_arg_d;
      accum_q      <= accum_d;
      digit_seen_q <= digit_seen_d;
      remain_q     <= remain_d;
      bcount_q     <= bcount_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ev_q     <= ev_d;
      db_q     <= db_d;
      idx_q    <= idx_d;
      done_q   <= done_d;
      bc_out_q <= bc_out_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = ev_q;
  assign data_byte_o      = db_q;
  assign arg_index_o      = idx_q;
  assign command_done_o   = done_q;
  assign bytes_consumed_o = bc_out_q;

endmodule
`default_nettype wire

[src/resp_command_stream_parser_top.sv]
// Top level of the RESP command stream parser.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------------
//   in      | in  | in_valid_i/in_stall_o| byte_in_i
//   out     | out | out_valid_o/out_stall_i | event_res_o, data_byte_o, arg_index_o,
//           |     |                      | command_done_o, bytes_consumed_o
//
// One byte per cycle sustained while out_stall_i holds no event back; the parser updates once per byte.
// An event becomes valid after its byte passes the queue and then the output register.
// A two-entry byte queue lets input and output stall independently.
// After reset the parser waits for '*'; a protocol error is sticky until reset.
`default_nettype none
module resp_command_stream_parser_top #(
  parameter int unsigned MAX_ARGS       = 1024,
  parameter int unsigned MAX_ARG_LENGTH = 1048576
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  arg_index_o,
  output logic        command_done_o,
  output logic [23:0] bytes_consumed_o
);
  import rcsp_pkg::*;

  logic        q_valid;
  byte_class_t q_entry;
  logic        q_pop;

  rcsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  rcsp_back #(
    .MAX_ARGS       (MAX_ARGS),
    .MAX_ARG_LENGTH (MAX_ARG_LENGTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_entry_i        (q_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_o      (event_res_o),
    .data_byte_o      (data_byte_o),
    .arg_index_o      (arg_index_o),
    .command_done_o   (command_done_o),
    .bytes_consumed_o (bytes_consumed_o)
  );

endmodule
`default_nettype wire
